FILE: rtl/core/mcrle_pkg.sv
// Shared types, widths and defaults for the multi-column run-length expander.
package mcrle_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 16;
    localparam int DEFAULT_RUN_ENTRIES = 1024;
    localparam int DEFAULT_ROW_BITS    = 16;

    localparam int CFG_W     = 5;
    localparam int PRED_W    = 4;
    localparam int ENTRY_W   = 10;
    localparam int VALUE_W   = 64;
    localparam int START_W   = 16;
    localparam int LEN_W     = 17;
    localparam int COL_OUT_W = 4;
    localparam int ROW_OUT_W = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_SET_START = 2'd1,
        CMD_EMIT      = 2'd2,
        CMD_RESTART   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                 command;
        logic [PRED_W-1:0]    pred_index;
        logic [ENTRY_W-1:0]   entry_index;
        logic [VALUE_W-1:0]   run_value;
        logic [START_W-1:0]   run_start_row;
        logic [LEN_W-1:0]     run_length;
    } in_word_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] column;
        logic [VALUE_W-1:0]   value;
        logic [ROW_OUT_W-1:0] row_number;
        logic                 last;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_entry;
        logic set_start;
        logic restart;
        logic begin_row;
        logic walk;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic row_top;
        logic row_end;
    } dp_status_t;

endpackage

FILE: rtl/core/mcrle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mcrle_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mcrle_ctrl.sv
// Controller state machine: decodes accepted words and sequences the row walk.
module mcrle_ctrl
    import mcrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  cmd_t       in_command,
    input  dp_status_t status,
    output logic       in_stall,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_command)
                        CMD_LOAD:      cmd.load_entry = 1'b1;
                        CMD_SET_START: cmd.set_start  = 1'b1;
                        CMD_RESTART:   cmd.restart    = 1'b1;
                        CMD_EMIT:
                        begin
                            // An emit past the top row is dropped without results.
                            if (!status.row_top)
                            begin
                                cmd.begin_row = 1'b1;
                                state_next    = S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.row_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/mcrle_datapath.sv
// Datapath: run table, per-column decode state, two-stage column walk and output register.
module mcrle_datapath
    import mcrle_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int RUN_ENTRIES = DEFAULT_RUN_ENTRIES,
    parameter int ROW_BITS    = DEFAULT_ROW_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    input  in_word_t         in_data,
    input  ctrl_cmd_t        cmd,
    input  logic             out_stall,
    output logic             out_valid,
    output out_word_t        out_data,
    output dp_status_t       status
);

    localparam int IDX_W  = $clog2(RUN_ENTRIES);
    localparam int CIDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int EXT_W  = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;
    localparam int SUM_W  = ((ROW_BITS > LEN_W) ? ROW_BITS : LEN_W) + 1;
    localparam int RAM_W  = VALUE_W + ROW_BITS + LEN_W;

    logic [CFG_W-1:0]    cfg_reg;
    logic [CMP_W-1:0]    cfg_ext;
    logic [CNT_W-1:0]    active;

    logic [IDX_W-1:0]    col_start_reg   [MAX_COLUMNS];
    logic [IDX_W-1:0]    col_start_next  [MAX_COLUMNS];
    logic [IDX_W-1:0]    next_entry_reg  [MAX_COLUMNS];
    logic [IDX_W-1:0]    next_entry_next [MAX_COLUMNS];
    logic [ROW_BITS:0]   change_row_reg  [MAX_COLUMNS];
    logic [ROW_BITS:0]   change_row_next [MAX_COLUMNS];
    logic [VALUE_W-1:0]  held_reg        [MAX_COLUMNS];
    logic [VALUE_W-1:0]  held_next       [MAX_COLUMNS];
    logic [ROW_BITS:0]   row_reg;
    logic [ROW_BITS:0]   row_next;

    logic [CNT_W-1:0]    iss_cnt_reg;
    logic [CNT_W-1:0]    iss_cnt_next;
    logic [CIDX_W-1:0]   iss_col;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic [CIDX_W-1:0]   res_col_reg;
    logic                res_hit_reg;
    logic                res_last_reg;
    logic [IDX_W-1:0]    res_idx_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    out_word_t           out_data_reg;
    out_word_t           out_data_next;

    logic                adv;
    logic                issuing;
    logic                resolve;

    logic [EXT_W-1:0]    entry_ext;
    logic                entry_in_range;
    logic [IDX_W-1:0]    entry_idx;
    logic                pred_in_range;
    logic [CIDX_W-1:0]   pred_col;

    logic [RAM_W-1:0]    ram_wr_data;
    logic [RAM_W-1:0]    ram_rd_data;
    logic [VALUE_W-1:0]  rd_value;
    logic [ROW_BITS-1:0] rd_start;
    logic [LEN_W-1:0]    rd_len;
    logic [SUM_W-1:0]    change_sum;
    logic [VALUE_W-1:0]  cur_value;

    // Column count: zero counts as one, anything above the build maximum is clipped.
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_reg);
        if (cfg_ext == '0)
        begin
            active = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_COLUMNS))
        begin
            active = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            active = CNT_W'(cfg_ext);
        end
    end

    assign entry_ext      = EXT_W'(in_data.entry_index);
    assign entry_in_range = (entry_ext < EXT_W'(RUN_ENTRIES));
    assign entry_idx      = entry_ext[IDX_W-1:0];
    assign pred_in_range  = (int'(in_data.pred_index) < MAX_COLUMNS);
    assign pred_col       = CIDX_W'(in_data.pred_index);

    assign ram_wr_data = {in_data.run_value, ROW_BITS'(in_data.run_start_row),
                          in_data.run_length};

    // The pipeline moves only when the output register is free or being emptied.
    assign adv     = !out_valid_reg || !out_stall;
    assign iss_col = iss_cnt_reg[CIDX_W-1:0];
    assign issuing = cmd.walk && adv && (iss_cnt_reg < active);
    assign resolve = cmd.walk && adv && res_valid_reg;

    mcrle_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RUN_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_run_table (
        .clk    (clk),
        .wr_en  (cmd.load_entry && entry_in_range),
        .wr_addr(entry_idx),
        .wr_data(ram_wr_data),
        .rd_en  (issuing),
        .rd_addr(next_entry_reg[iss_col]),
        .rd_data(ram_rd_data)
    );

    assign rd_value   = ram_rd_data[RAM_W-1 -: VALUE_W];
    assign rd_start   = ram_rd_data[LEN_W +: ROW_BITS];
    assign rd_len     = ram_rd_data[LEN_W-1:0];
    assign change_sum = SUM_W'(rd_start) + SUM_W'(rd_len);
    assign cur_value  = res_hit_reg ? rd_value : held_reg[res_col_reg];

    always_comb
    begin
        col_start_next  = col_start_reg;
        next_entry_next = next_entry_reg;
        change_row_next = change_row_reg;
        held_next       = held_reg;
        row_next        = row_reg;

        if (cmd.set_start && pred_in_range)
        begin
            col_start_next[pred_col] = entry_idx;
        end

        if (cmd.restart)
        begin
            row_next = '0;
            for (int c = 0; c < MAX_COLUMNS; c++)
            begin
                change_row_next[c] = '0;
                next_entry_next[c] = col_start_reg[c];
            end
        end

        if (resolve)
        begin
            if (res_hit_reg)
            begin
                held_next[res_col_reg]       = rd_value;
                change_row_next[res_col_reg] = change_sum[ROW_BITS:0];
                next_entry_next[res_col_reg] = res_idx_reg + IDX_W'(1);
            end
            if (res_last_reg)
            begin
                row_next = row_reg + (ROW_BITS + 1)'(1);
            end
        end
    end

    always_comb
    begin
        iss_cnt_next   = iss_cnt_reg;
        res_valid_next = res_valid_reg;
        if (cmd.begin_row)
        begin
            iss_cnt_next   = '0;
            res_valid_next = 1'b0;
        end
        else if (cmd.walk && adv)
        begin
            res_valid_next = issuing;
            if (issuing)
            begin
                iss_cnt_next = iss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            out_valid_next           = resolve;
            out_data_next.column     = COL_OUT_W'(res_col_reg);
            out_data_next.value      = cur_value;
            out_data_next.row_number = ROW_OUT_W'(row_reg);
            out_data_next.last       = res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            row_reg       <= '0;
            iss_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_COLUMNS; c++)
            begin
                col_start_reg[c]  <= '0;
                next_entry_reg[c] <= '0;
                change_row_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                cfg_reg <= cfg_write_data;
            end
            row_reg         <= row_next;
            iss_cnt_reg     <= iss_cnt_next;
            res_valid_reg   <= res_valid_next;
            out_valid_reg   <= out_valid_next;
            col_start_reg   <= col_start_next;
            next_entry_reg  <= next_entry_next;
            change_row_reg  <= change_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        out_data_reg <= out_data_next;
        if (issuing)
        begin
            res_col_reg  <= iss_col;
            res_hit_reg  <= (row_reg == change_row_reg[iss_col]);
            res_last_reg <= (iss_cnt_reg == active - CNT_W'(1));
            res_idx_reg  <= next_entry_reg[iss_col];
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign status.row_top = row_reg[ROW_BITS];
    assign status.row_end = resolve && res_last_reg;

endmodule

FILE: rtl/core/multi_column_run_length_expander.sv
// Top level of the multi-column run-length expander.
// Load, set-start and restart words are accepted without stalling the input. An emit
// word that is not past the top row produces one output word per active column: once
// it is accepted, the walk visits the columns in turn through the single read port of
// the run table, and each read is registered before its word enters the output
// register; output stalls hold the walk. The input is stalled from the cycle after such
// an emit is accepted until the last column of the row has entered the output register.
// RUN_ENTRIES must be a power of two; the run table has no reset and needs no clearing
// pass, so the block is ready right after reset.
module multi_column_run_length_expander
    import mcrle_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int RUN_ENTRIES = DEFAULT_RUN_ENTRIES,
    parameter int ROW_BITS    = DEFAULT_ROW_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mcrle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_command(in_data.command),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    mcrle_datapath #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .RUN_ENTRIES(RUN_ENTRIES),
        .ROW_BITS   (ROW_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_data       (in_data),
        .cmd           (cmd),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_data      (out_data),
        .status        (status)
    );

endmodule
